### rtl/lmrs_pkg.sv
// Package for the LED matrix row scanner: geometry constants, derived widths,
// operation codes and the pixel store write request type.
// No dependencies.
`default_nettype none

package lmrs_pkg;

	// Matrix geometry
	localparam int CHANNELS   = 16;
	localparam int ROWS       = 8;
	localparam int BUF_LEN    = ROWS * CHANNELS;
	localparam int MEM_DEPTH  = 2 * BUF_LEN;
	localparam int MEM_AW     = $clog2(MEM_DEPTH);
	localparam int CNT_W      = $clog2(BUF_LEN + 1);
	localparam int ROW_W      = (ROWS > 1) ? $clog2(ROWS) : 1;

	// Field widths of the transaction ports
	localparam int OP_W       = 2;
	localparam int PIX_W      = 7;
	localparam int BRIGHT_W   = 8;
	localparam int ROW_FW     = 3;
	localparam int CH_FW      = 4;
	localparam int GRAY_W     = 12;
	localparam int GRAY_SHIFT = 4;

	// Operation codes
	localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
	localparam logic [OP_W-1:0] OP_FLIP  = 2'd1;
	localparam logic [OP_W-1:0] OP_TICK  = 2'd2;

	// One write into the pixel store
	typedef struct packed {
		logic                en;
		logic [MEM_AW-1:0]   addr;
		logic [BRIGHT_W-1:0] data;
	} wr_req_t;

endpackage

`default_nettype wire

### rtl/lmrs_store.sv
// Pixel store: both frame buffers in one memory, one write and one registered read
// a cycle, with per-entry valid bits so that unwritten entries read as zero.
// Depends on lmrs_pkg.
`default_nettype none

module lmrs_store
	import lmrs_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire wr_req_t             wr,
	input  wire logic [MEM_AW-1:0]   rd_addr,
	output      logic [BRIGHT_W-1:0] rd_data
);

	logic [BRIGHT_W-1:0]  mem [MEM_DEPTH];
	logic [MEM_DEPTH-1:0] valid_q;
	logic [BRIGHT_W-1:0]  rd_data_q;
	logic                 rd_valid_q;

	// Write port
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	// Mark written entries; reset leaves every entry reading as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr.en) begin
				valid_q[wr.addr] <= 1'b1;
			end
			rd_valid_q <= valid_q[rd_addr];
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_valid_q ? rd_data_q : '0;

endmodule

`default_nettype wire

### rtl/led_matrix_row_scan_refresh.sv
// Double-buffered LED matrix row scanner, top level: command sequencer, buffer
// select, row counter and result registers around the pixel store.
// Depends on lmrs_pkg and lmrs_store.
//
//  Channel   Handshake           Payload
//  --------  ------------------  ------------------------------------------
//  command   start / busy        operation, pixel_index, brightness
//  result    strobe (no stall)   row, channel, grayscale, last_of_row
//
// A command is taken at a clock edge with start high and busy low.
// Write: busy stays low. Flip: busy while the front buffer is copied, one
// entry a cycle through the single read port of the pixel store.
// Row tick: busy, one word read a cycle; results pass the store's read register
// and the result registers, one per cycle, strobe high for one cycle.
// Reset clears the sequencer, buffer select, row counter and the store's valid
// bits; no clearing pass is needed. The receiver cannot stall results.
`default_nettype none

module led_matrix_row_scan_refresh
	import lmrs_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output      logic                busy,
	input  wire logic [OP_W-1:0]     operation,
	input  wire logic [PIX_W-1:0]    pixel_index,
	input  wire logic [BRIGHT_W-1:0] brightness,
	output      logic                strobe,
	output      logic [ROW_FW-1:0]   row,
	output      logic [CH_FW-1:0]    channel,
	output      logic [GRAY_W-1:0]   grayscale,
	output      logic                last_of_row
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_COPY = 2'd1;
	localparam logic [1:0] ST_SCAN = 2'd2;

	logic [1:0]          state_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                front_q;
	logic [ROW_W-1:0]    row_q;
	logic                accept;
	logic [MEM_AW-1:0]   front_base;
	logic [MEM_AW-1:0]   back_base;
	logic [MEM_AW-1:0]   rd_addr;
	logic [BRIGHT_W-1:0] rd_data;
	wr_req_t             wr;
	logic                strobe_q;
	logic [ROW_FW-1:0]   row_out_q;
	logic [CH_FW-1:0]    channel_q;
	logic [GRAY_W-1:0]   grayscale_q;
	logic                last_q;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	assign front_base = front_q ? MEM_AW'(BUF_LEN) : '0;
	assign back_base  = front_q ? '0 : MEM_AW'(BUF_LEN);

	// Read address: front buffer entry for a copy, current row word for a scan
	always_comb begin
		unique case (state_q)
			ST_COPY: rd_addr = front_base + MEM_AW'(cnt_q);
			ST_SCAN: rd_addr = front_base + MEM_AW'(row_q) * MEM_AW'(CHANNELS)
				+ MEM_AW'(cnt_q);
			default: rd_addr = '0;
		endcase
	end

	// Write request: pixel write on accept, or copy data in the cycle after its read
	always_comb begin
		wr.en   = 1'b0;
		wr.addr = '0;
		wr.data = '0;
		if (accept && operation == OP_WRITE
			&& (PIX_W + 1)'(pixel_index) < (PIX_W + 1)'(BUF_LEN)) begin
			wr.en   = 1'b1;
			wr.addr = back_base + MEM_AW'(pixel_index);
			wr.data = brightness;
		end else if (state_q == ST_COPY && cnt_q != '0) begin
			wr.en   = 1'b1;
			wr.addr = back_base + MEM_AW'(cnt_q - CNT_W'(1));
			wr.data = rd_data;
		end
	end

	lmrs_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (wr),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Sequencer, buffer select and row counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			front_q <= 1'b0;
			row_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (accept && operation == OP_FLIP) begin
						front_q <= ~front_q;
						state_q <= ST_COPY;
					end else if (accept && operation == OP_TICK) begin
						state_q <= ST_SCAN;
					end
				end
				ST_COPY: begin
					if (cnt_q == CNT_W'(BUF_LEN)) begin
						state_q <= ST_IDLE;
					end
					cnt_q <= cnt_q + CNT_W'(1);
				end
				ST_SCAN: begin
					if (cnt_q == CNT_W'(CHANNELS)) begin
						state_q <= ST_IDLE;
						row_q   <= (row_q == ROW_W'(ROWS - 1)) ? '0 : row_q + ROW_W'(1);
					end
					cnt_q <= cnt_q + CNT_W'(1);
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result strobe: one transaction per read word of the scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= (state_q == ST_SCAN) && (cnt_q != '0);
		end
	end

	// Result payload, loaded as each scan word returns from the store
	always_ff @(posedge clk) begin
		if (state_q == ST_SCAN && cnt_q != '0) begin
			row_out_q   <= ROW_FW'(row_q);
			channel_q   <= CH_FW'(cnt_q - CNT_W'(1));
			grayscale_q <= GRAY_W'({rd_data, {GRAY_SHIFT{1'b0}}});
			last_q      <= (cnt_q == CNT_W'(CHANNELS));
		end
	end

	assign strobe      = strobe_q;
	assign row         = row_out_q;
	assign channel     = channel_q;
	assign grayscale   = grayscale_q;
	assign last_of_row = last_q;

endmodule

`default_nettype wire

### test/testbench.sv
`timescale 1ns / 100ps
// Testbench for the double-buffered LED matrix row scanner: drives write, flip, row tick
// and spare commands with random gaps and checks every grayscale word against a local
// model of both pixel buffers. Depends on lmrs_pkg and led_matrix_row_scan_refresh.

module testbench;
	import lmrs_pkg::*;

	// Operation code that the block must ignore
	localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
	localparam int CLK_HALF      = 4;
	localparam int RESET_CYCLES  = 6;
	localparam int RANDOM_ITEMS  = 400;
	localparam int WATCHDOG_MAX  = 2000;
	localparam int DRAIN_CYCLES  = 160;
	localparam int PRINT_MAX     = 40;

	typedef struct {
		logic [OP_W-1:0]     op;
		logic [PIX_W-1:0]    idx;
		logic [BRIGHT_W-1:0] level;
	} command_t;

	typedef struct {
		logic [ROW_FW-1:0] row;
		logic [CH_FW-1:0]  channel;
		logic [GRAY_W-1:0] grayscale;
		logic              last_of_row;
	} scan_word_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic                busy;
	logic [OP_W-1:0]     operation = OP_WRITE;
	logic [PIX_W-1:0]    pixel_index = '0;
	logic [BRIGHT_W-1:0] brightness = '0;
	logic                strobe;
	logic [ROW_FW-1:0]   row;
	logic [CH_FW-1:0]    channel;
	logic [GRAY_W-1:0]   grayscale;
	logic                last_of_row;

	// Model state: both halves of the pixel store, displayed half, row counter
	logic [BRIGHT_W-1:0] pixel_copy [MEM_DEPTH];
	logic                shown_half = 1'b0;
	int                  scan_row = 0;

	command_t   command_queue [$];
	scan_word_t pending_words [$];
	command_t   in_flight;

	int error_count = 0;
	int commands_taken = 0;
	int words_checked = 0;
	int op_count [4] = '{0, 0, 0, 0};
	int quiet_cycles = 0;
	bit timed_out = 1'b0;

	led_matrix_row_scan_refresh i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.operation   (operation),
		.pixel_index (pixel_index),
		.brightness  (brightness),
		.strobe      (strobe),
		.row         (row),
		.channel     (channel),
		.grayscale   (grayscale),
		.last_of_row (last_of_row)
	);

	always #(CLK_HALF) clk = ~clk;

	task automatic report(input string what);
		error_count++;
		if (error_count <= PRINT_MAX) begin
			$display("[%0t] mismatch: %s", $time, what);
		end
	endtask

	task automatic queue_command(input logic [OP_W-1:0] op, input int idx, input int level);
		command_t c;
		c.op = op;
		c.idx = PIX_W'(idx);
		c.level = BRIGHT_W'(level);
		command_queue.push_back(c);
	endtask

	// Apply one accepted command to the buffer model and queue the words a tick emits
	task automatic update_matrix(input command_t c);
		int front_base;
		int back_base;
		scan_word_t w;
		op_count[c.op]++;
		case (c.op)
			OP_WRITE: begin
				back_base = shown_half ? 0 : BUF_LEN;
				if (int'(c.idx) < BUF_LEN) begin
					pixel_copy[back_base + int'(c.idx)] = c.level;
				end
			end
			OP_FLIP: begin
				shown_half = ~shown_half;
				front_base = shown_half ? BUF_LEN : 0;
				back_base = shown_half ? 0 : BUF_LEN;
				for (int i = 0; i < BUF_LEN; i++) begin
					pixel_copy[back_base + i] = pixel_copy[front_base + i];
				end
			end
			OP_TICK: begin
				front_base = (shown_half ? BUF_LEN : 0) + scan_row * CHANNELS;
				for (int ch = 0; ch < CHANNELS; ch++) begin
					w.row = ROW_FW'(scan_row);
					w.channel = CH_FW'(ch);
					w.grayscale = GRAY_W'(pixel_copy[front_base + ch]) << GRAY_SHIFT;
					w.last_of_row = (ch == CHANNELS - 1);
					pending_words.push_back(w);
				end
				scan_row = (scan_row + 1) % ROWS;
			end
			default: begin
			end
		endcase
	endtask

	// Drive commands from the queue; the idle share depends on how far the run has got
	always @(posedge clk) begin : command_driver
		command_t cmd;
		int idle_pct;
		if (arst_n) begin
			if (start && !busy) begin
				update_matrix(in_flight);
				commands_taken++;
			end
			if (commands_taken < 120) begin
				idle_pct = 0;
			end else if (commands_taken < 240) begin
				idle_pct = 53;
			end else if (commands_taken < 330) begin
				idle_pct = 12;
			end else begin
				idle_pct = 0;
			end
			// Hold the transaction while busy; otherwise load the next one or idle
			if (!start || !busy) begin
				if (command_queue.size() > 0 && $urandom_range(99) >= idle_pct) begin
					cmd = command_queue.pop_front();
					in_flight = cmd;
					start <= 1'b1;
					operation <= cmd.op;
					pixel_index <= cmd.idx;
					brightness <= cmd.level;
				end else begin
					start <= 1'b0;
					operation <= OP_W'($urandom);
					pixel_index <= PIX_W'($urandom);
					brightness <= BRIGHT_W'($urandom);
				end
			end
		end
	end

	// Compare each strobed word with the oldest expected one
	always @(posedge clk) begin : result_monitor
		scan_word_t want;
		if (arst_n && strobe) begin
			if (pending_words.size() == 0) begin
				report($sformatf("unexpected word row %0d channel %0d grayscale %0d",
					row, channel, grayscale));
			end else begin
				want = pending_words.pop_front();
				words_checked++;
				if (row !== want.row) begin
					report($sformatf("row %0d, want %0d", row, want.row));
				end
				if (channel !== want.channel) begin
					report($sformatf("channel %0d, want %0d (row %0d)",
						channel, want.channel, want.row));
				end
				if (grayscale !== want.grayscale) begin
					report($sformatf("grayscale %0d, want %0d (row %0d channel %0d)",
						grayscale, want.grayscale, want.row, want.channel));
				end
				if (last_of_row !== want.last_of_row) begin
					report($sformatf("last_of_row %b, want %b (row %0d channel %0d)",
						last_of_row, want.last_of_row, want.row, want.channel));
				end
			end
		end
	end

	// Stop the run when no transaction moves for too long
	always @(posedge clk) begin : watchdog
		if (arst_n && !timed_out) begin
			if ((start && !busy) || strobe) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= WATCHDOG_MAX) begin
				report($sformatf("no transaction for %0d cycles", WATCHDOG_MAX));
				timed_out = 1'b1;
			end
		end
	end

	initial begin : main_sequence
		int counted;
		int pick;
		scan_word_t left;
		for (int i = 0; i < MEM_DEPTH; i++) begin
			pixel_copy[i] = '0;
		end

		// Directed: extremes and alternating bit patterns, scan before and after flips,
		// the spare operation, and a full pass of rows so the counter wraps
		queue_command(OP_TICK, 0, 0);
		queue_command(OP_WRITE, 0, 255);
		queue_command(OP_WRITE, BUF_LEN - 1, 255);
		queue_command(OP_WRITE, 85, 8'hAA);
		queue_command(OP_WRITE, 42, 8'h55);
		queue_command(OP_WRITE, 15, 1);
		queue_command(OP_SPARE, 127, 255);
		queue_command(OP_TICK, 0, 0);
		queue_command(OP_FLIP, 127, 255);
		for (int r = 0; r < ROWS; r++) begin
			queue_command(OP_TICK, 127, 255);
		end
		queue_command(OP_WRITE, 16, 128);
		queue_command(OP_TICK, 0, 0);
		queue_command(OP_FLIP, 0, 0);
		queue_command(OP_TICK, 0, 0);
		queue_command(OP_TICK, 0, 0);
		queue_command(OP_TICK, 0, 0);

		// Random: mostly writes and row ticks, with flips and the odd spare command
		counted = 0;
		while (counted < RANDOM_ITEMS) begin
			pick = $urandom_range(99);
			if (pick < 56) begin
				queue_command(OP_WRITE, $urandom_range(BUF_LEN - 1),
					($urandom_range(9) == 0) ? 255 * $urandom_range(1) : $urandom_range(255));
				counted++;
			end else if (pick < 64) begin
				queue_command(OP_FLIP, $urandom_range(127), $urandom_range(255));
				counted++;
			end else if (pick < 96) begin
				queue_command(OP_TICK, $urandom_range(127), $urandom_range(255));
				counted++;
			end else begin
				queue_command(OP_SPARE, $urandom_range(127), $urandom_range(255));
			end
		end

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Wait for every command to be taken and every word to arrive
		while (!timed_out &&
			!(command_queue.size() == 0 && !start && pending_words.size() == 0)) begin
			@(posedge clk);
		end
		if (!timed_out) begin
			repeat (DRAIN_CYCLES) @(posedge clk);
		end
		while (pending_words.size() > 0) begin
			left = pending_words.pop_front();
			report($sformatf("word row %0d channel %0d never arrived", left.row, left.channel));
		end

		$display("Run: %0d commands (%0d writes, %0d flips, %0d row ticks, %0d spare),",
			commands_taken, op_count[OP_WRITE], op_count[OP_FLIP], op_count[OP_TICK],
			op_count[OP_SPARE]);
		$display("     %0d grayscale words compared, %0d errors", words_checked, error_count);
		if (!timed_out && error_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
